FILE: design/assert_macros.svh
// Assertion macros used by the RTL controller (dfl_ctrl).
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define DFL_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define DFL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

FILE: design/dfl_pkg.sv
// Package: widths, controller states and control structs of the delayed low-pass filter.
`timescale 1ns / 1ps
package dfl_pkg;

  localparam int DELAY_DEPTH  = 10;
  localparam int SAMPLE_WIDTH = 16;
  localparam int TICK_WIDTH   = 16;

  localparam int PROD_W = TICK_WIDTH + SAMPLE_WIDTH + 1;
  localparam int SUM_W  = PROD_W + 1;
  localparam int MAG_W  = PROD_W;
  localparam int DEN_W  = TICK_WIDTH + 1;
  localparam int QUO_W  = SAMPLE_WIDTH;
  localparam int CNT_W  = (QUO_W > 1) ? $clog2(QUO_W) : 1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_A,
    ST_MUL_B,
    ST_SUM,
    ST_DIV,
    ST_FIN
  } state_e;

  typedef struct packed {
    logic load;
    logic mul_a;
    logic mul_b;
    logic sum;
    logic div_step;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic div_last;
  } status_t;

endpackage

FILE: design/delayed_first_order_lowpass.sv
// An accepted item passes ST_MUL_A, ST_MUL_B, ST_SUM and ST_DIV, and in ST_FIN its
// result is registered on the output. A 16-step restoring divider (one quotient bit
// per cycle) runs in ST_DIV; a new item is taken only in ST_IDLE, after the last one.
// A waiting result does not block the next item until its divide completes.
// Reset (async, active low) clears the delay line, last output and time constant;
// a time-constant write clears the delay line and last output.
`timescale 1ns / 1ps
module delayed_first_order_lowpass
  import dfl_pkg::*;
(
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic        [TICK_WIDTH-1:0]   cfg_wdata_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic signed [SAMPLE_WIDTH-1:0] sample_i,
  input  logic        [TICK_WIDTH-1:0]   step_ticks_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic signed [SAMPLE_WIDTH-1:0] filtered_o
);

  cmd_t    cmd;
  status_t status;

  dfl_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  dfl_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .sample_i    (sample_i),
    .step_ticks_i(step_ticks_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .filtered_o  (filtered_o)
  );

endmodule

FILE: design/dfl_datapath.sv
// Datapath: delay line, filter state, products, sum and restoring divider.
`timescale 1ns / 1ps
module dfl_datapath
  import dfl_pkg::*;
(
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic        [TICK_WIDTH-1:0]   cfg_wdata_i,
  input  logic signed [SAMPLE_WIDTH-1:0] sample_i,
  input  logic        [TICK_WIDTH-1:0]   step_ticks_i,
  input  cmd_t                           cmd_i,
  output status_t                        status_o,
  output logic signed [SAMPLE_WIDTH-1:0] filtered_o
);

  logic        [TICK_WIDTH-1:0]   tc_q;
  logic signed [SAMPLE_WIDTH-1:0] dline_q [DELAY_DEPTH];
  logic signed [SAMPLE_WIDTH-1:0] last_q;
  logic        [TICK_WIDTH-1:0]   dt_q;
  logic signed [SAMPLE_WIDTH-1:0] leave_q;
  logic        [DEN_W-1:0]        den_q;
  logic signed [PROD_W-1:0]       prod_a_q;
  logic signed [PROD_W-1:0]       prod_b_q;
  logic                           neg_q;
  logic                           zden_q;
  logic        [DEN_W-1:0]        rem_q;
  logic        [QUO_W-1:0]        quo_q;
  logic        [CNT_W-1:0]        cnt_q;
  logic signed [SAMPLE_WIDTH-1:0] out_q;

  logic signed [DEN_W-1:0]        tc_s;
  logic signed [DEN_W-1:0]        dt_s;
  logic signed [PROD_W-1:0]       prod_a_d;
  logic signed [PROD_W-1:0]       prod_b_d;
  logic signed [SUM_W-1:0]        sum_d;
  logic        [SUM_W-1:0]        mag_full;
  logic        [MAG_W-1:0]        mag_d;
  logic        [DEN_W:0]          rem_sh;
  logic        [DEN_W:0]          rem_sub;
  logic                           fits;
  logic signed [SAMPLE_WIDTH-1:0] result_d;

  always_comb begin
    tc_s     = $signed({1'b0, tc_q});
    dt_s     = $signed({1'b0, dt_q});
    prod_a_d = tc_s * last_q;
    prod_b_d = dt_s * leave_q;
    sum_d    = SUM_W'(prod_a_q) + SUM_W'(prod_b_q);
    mag_full = sum_d[SUM_W-1] ? SUM_W'(-sum_d) : SUM_W'(sum_d);
    mag_d    = mag_full[MAG_W-1:0];
    rem_sh   = {rem_q, quo_q[QUO_W-1]};
    rem_sub  = rem_sh - {1'b0, den_q};
    fits     = (rem_sh >= {1'b0, den_q});
    if (zden_q) begin
      result_d = last_q;
    end else if (neg_q) begin
      result_d = $signed(-quo_q);
    end else begin
      result_d = $signed(quo_q);
    end
  end

  // History registers: cleared by reset and by a time-constant write.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tc_q   <= '0;
      last_q <= '0;
      for (int i = 0; i < DELAY_DEPTH; i++) begin
        dline_q[i] <= '0;
      end
    end else if (cfg_we_i) begin
      tc_q   <= cfg_wdata_i;
      last_q <= '0;
      for (int i = 0; i < DELAY_DEPTH; i++) begin
        dline_q[i] <= '0;
      end
    end else begin
      if (cmd_i.load) begin
        dline_q[0] <= sample_i;
        for (int i = 1; i < DELAY_DEPTH; i++) begin
          dline_q[i] <= dline_q[i-1];
        end
      end
      if (cmd_i.finish) begin
        last_q <= result_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      dt_q    <= step_ticks_i;
      leave_q <= dline_q[DELAY_DEPTH-1];
      den_q   <= {1'b0, tc_q} + {1'b0, step_ticks_i};
    end
    if (cmd_i.mul_a) begin
      prod_a_q <= prod_a_d;
    end
    if (cmd_i.mul_b) begin
      prod_b_q <= prod_b_d;
    end
    if (cmd_i.sum) begin
      neg_q  <= sum_d[SUM_W-1];
      zden_q <= (den_q == '0);
      rem_q  <= mag_d[MAG_W-1:QUO_W];
      quo_q  <= mag_d[QUO_W-1:0];
      cnt_q  <= CNT_W'(QUO_W - 1);
    end
    if (cmd_i.div_step) begin
      rem_q <= fits ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
      quo_q <= {quo_q[QUO_W-2:0], fits};
      cnt_q <= cnt_q - 1'b1;
    end
    if (cmd_i.finish) begin
      out_q <= result_d;
    end
  end

  assign status_o.div_last = (cnt_q == '0);
  assign filtered_o        = out_q;

endmodule

FILE: design/dfl_ctrl.sv
// Controller: sequences multiply, sum, divide and output handoff for one item.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module dfl_ctrl
  import dfl_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_stall_o,
  output logic    out_valid_o,
  input  logic    out_stall_i,
  input  status_t status_i,
  output cmd_t    cmd_o
);

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_stall_o  = 1'b1;
    out_valid_d = out_valid_q && out_stall_i;
    case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_MUL_A;
        end
      end
      ST_MUL_A: begin
        cmd_o.mul_a = 1'b1;
        state_d     = ST_MUL_B;
      end
      ST_MUL_B: begin
        cmd_o.mul_b = 1'b1;
        state_d     = ST_SUM;
      end
      ST_SUM: begin
        cmd_o.sum = 1'b1;
        state_d   = ST_DIV;
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (status_i.div_last) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.finish = 1'b1;
          out_valid_d  = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;

  `DFL_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, in_valid_i && !in_stall_o, in_stall_o)
  `DFL_ASSERT_NEXT(a_finish_shows_item, clk_i, rst_ni, cmd_o.finish, out_valid_o)
  `DFL_ASSERT_IMPL(a_one_cmd, clk_i, rst_ni, 1'b1, $onehot0(cmd_o))
  `DFL_ASSERT_IMPL(a_no_overwrite, clk_i, rst_ni, cmd_o.finish, !out_valid_q || !out_stall_i)
  `DFL_ASSERT_NEXT(a_div_ends, clk_i, rst_ni, state_q == ST_DIV && status_i.div_last,
                   state_q == ST_FIN)

endmodule

FILE: tb/sv/delayed_first_order_lowpass_tb.sv
`timescale 1ns / 1ps
// Testbench: delayed low-pass filter, random and directed items, checked against a local predictor.
module delayed_first_order_lowpass_tb;
  import dfl_pkg::*;

  localparam int HALF_PERIOD  = 6;
  localparam int SETTLE_WAIT  = 30;
  localparam int STALL_LIMIT  = 5000;
  localparam int HOLD_CYCLES  = 300;
  localparam int RAND_PHASES  = 7;
  localparam int PHASE_ITEMS  = 118;
  localparam int MAX_REPORTS  = 50;

  typedef struct packed {
    logic signed [SAMPLE_WIDTH-1:0] sample;
    logic        [TICK_WIDTH-1:0]   ticks;
  } lp_item_t;

  logic                           clk_i        = 1'b0;
  logic                           rst_ni       = 1'b0;
  logic                           cfg_we_i     = 1'b0;
  logic        [TICK_WIDTH-1:0]   cfg_wdata_i  = '0;
  logic                           in_valid_i   = 1'b0;
  logic                           in_stall_o;
  logic signed [SAMPLE_WIDTH-1:0] sample_i     = '0;
  logic        [TICK_WIDTH-1:0]   step_ticks_i = '0;
  logic                           out_valid_o;
  logic                           out_stall_i  = 1'b0;
  logic signed [SAMPLE_WIDTH-1:0] filtered_o;

  delayed_first_order_lowpass uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .sample_i    (sample_i),
    .step_ticks_i(step_ticks_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .filtered_o  (filtered_o)
  );

  always #HALF_PERIOD clk_i = ~clk_i;

  // predictor state
  logic signed [SAMPLE_WIDTH-1:0] delay_hist [DELAY_DEPTH];
  logic signed [SAMPLE_WIDTH-1:0] prev_filtered;
  logic        [TICK_WIDTH-1:0]   tau_ticks;

  lp_item_t                       pending_q [$];
  logic signed [SAMPLE_WIDTH-1:0] filtered_q [$];

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  bit hold_armed     = 1'b0;
  bit hold_used      = 1'b0;
  int hold_left      = 0;
  int errors         = 0;
  int items_sent     = 0;
  int results_seen   = 0;
  int quiet_cycles   = 0;

  task automatic clear_filter_history();
    for (int i = 0; i < DELAY_DEPTH; i++) delay_hist[i] = '0;
    prev_filtered = '0;
  endtask

  task automatic predict_filtered(input logic signed [SAMPLE_WIDTH-1:0] x,
                                  input logic [TICK_WIDTH-1:0] dt);
    logic signed [SAMPLE_WIDTH-1:0] leaving;
    longint num;
    longint den;
    leaving = delay_hist[DELAY_DEPTH-1];
    for (int i = DELAY_DEPTH - 1; i > 0; i--) delay_hist[i] = delay_hist[i-1];
    delay_hist[0] = x;
    den = longint'(tau_ticks) + longint'(dt);
    if (den != 0) begin
      num = longint'(tau_ticks) * longint'(prev_filtered) + longint'(dt) * longint'(leaving);
      prev_filtered = SAMPLE_WIDTH'(num / den);
    end
    filtered_q.push_back(prev_filtered);
  endtask

  task automatic queue_item(input logic signed [SAMPLE_WIDTH-1:0] s,
                            input logic [TICK_WIDTH-1:0] t);
    lp_item_t it;
    it.sample = s;
    it.ticks  = t;
    pending_q.push_back(it);
  endtask

  task automatic queue_random_item();
    logic signed [SAMPLE_WIDTH-1:0] s;
    logic        [TICK_WIDTH-1:0]   t;
    case ($urandom_range(9))
      0:       s = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
      1:       s = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
      default: s = SAMPLE_WIDTH'($urandom);
    endcase
    case ($urandom_range(9))
      0:          t = '0;
      1:          t = '1;
      2, 3, 4:    t = TICK_WIDTH'($urandom_range(255));
      default:    t = TICK_WIDTH'($urandom);
    endcase
    queue_item(s, t);
  endtask

  task automatic write_time_constant(input logic [TICK_WIDTH-1:0] v);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    tau_ticks = v;
    clear_filter_history();
  endtask

  task automatic wait_drained();
    while (pending_q.size() != 0 || filtered_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_WAIT) @(posedge clk_i);
  endtask

  // driver
  always @(posedge clk_i) begin
    logic offer;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        predict_filtered(sample_i, step_ticks_i);
        void'(pending_q.pop_front());
        items_sent++;
      end
      if (in_valid_i && in_stall_o) begin
        offer = 1'b1;
      end else begin
        offer = (pending_q.size() != 0) && ($urandom_range(99) >= send_idle_pct);
        if (offer) begin
          sample_i     <= pending_q[0].sample;
          step_ticks_i <= pending_q[0].ticks;
        end
      end
      in_valid_i <= offer;
    end
  end

  // monitor
  always @(posedge clk_i) begin
    logic signed [SAMPLE_WIDTH-1:0] want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (filtered_q.size() == 0) begin
          errors++;
          if (errors <= MAX_REPORTS)
            $display("%0t: filtered expected none actual %0d", $time, filtered_o);
        end else begin
          want = filtered_q.pop_front();
          results_seen++;
          if (filtered_o !== want) begin
            errors++;
            if (errors <= MAX_REPORTS)
              $display("%0t: filtered expected %0d actual %0d", $time, want, filtered_o);
          end
        end
      end
      if (hold_armed && !hold_used) begin
        hold_used = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) hold_left = hold_left - 1;
      out_stall_i <= (hold_left > 0) || ($urandom_range(99) < recv_stall_pct);
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("%0t: no progress for %0d cycles", $time, quiet_cycles);
        $display("delayed_first_order_lowpass_tb NOT OK");
        $finish;
      end
    end
  end

  initial begin
    int idle_modes [4][2];
    logic [TICK_WIDTH-1:0] tau_plan [RAND_PHASES];
    idle_modes = '{'{0, 0}, '{49, 0}, '{0, 49}, '{14, 14}};
    tau_plan   = '{16'd0, 16'hFFFF, 16'd1, TICK_WIDTH'($urandom_range(1000)),
                   TICK_WIDTH'($urandom), 16'd0, 16'hFFFF};
    tau_ticks = '0;
    clear_filter_history();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // zero time constant: output follows the delayed sample, holds when dt is zero
    write_time_constant('0);
    @(negedge clk_i);
    queue_item(16'sh7FFF, 16'd1);
    queue_item(16'sh8000, 16'hFFFF);
    queue_item(-16'sd1, 16'd0);
    queue_item(16'sd1, 16'd0);
    queue_item(16'sd0, 16'd100);
    queue_item(16'sd12345, 16'd7);
    queue_item(-16'sd12345, 16'hFFFF);
    queue_item(16'sh7FFF, 16'd0);
    queue_item(16'sh8000, 16'd1);
    queue_item(16'sd100, 16'd2);
    queue_item(-16'sd100, 16'd3);
    queue_item(16'sd500, 16'd1);
    queue_item(-16'sd500, 16'd0);
    wait_drained();

    // largest time constant with extreme samples and steps
    write_time_constant('1);
    @(negedge clk_i);
    for (int i = 0; i < 12; i++)
      queue_item((i % 2) ? 16'sh8000 : 16'sh7FFF, (i % 5 == 3) ? 16'd0 : 16'hFFFF);
    wait_drained();

    for (int p = 0; p < RAND_PHASES; p++) begin
      write_time_constant(tau_plan[p]);
      @(negedge clk_i);
      send_idle_pct  = idle_modes[p % 4][0];
      recv_stall_pct = idle_modes[p % 4][1];
      for (int i = 0; i < PHASE_ITEMS; i++) queue_random_item();
      if (p == 4) hold_armed = 1'b1;
      wait_drained();
      hold_armed = 1'b0;
    end

    $display("covered %0d items and %0d results over %0d time-constant settings",
             items_sent, results_seen, RAND_PHASES + 2);
    $display("idle and stall mixes on both sides, plus one long output hold-off");
    if (errors == 0 && filtered_q.size() == 0) begin
      $display("delayed_first_order_lowpass_tb OK");
    end else begin
      $display("delayed_first_order_lowpass_tb NOT OK");
    end
    $finish;
  end

endmodule
